FILE: rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 21;
    localparam int unsigned MinW   = 17;
    localparam int unsigned LeftW  = 2;

    localparam logic [ByteW-1:0] Mask2Lead = 8'h1F;
    localparam logic [ByteW-1:0] Mask3Lead = 8'h0F;
    localparam logic [ByteW-1:0] Mask4Lead = 8'h07;
    localparam logic [ByteW-1:0] MaskCont  = 8'h3F;

    localparam logic [MinW-1:0] Min2 = 17'h00080;
    localparam logic [MinW-1:0] Min3 = 17'h00800;
    localparam logic [MinW-1:0] Min4 = 17'h10000;

    localparam logic [CpW-1:0] CpLimit   = 21'h110000;
    localparam logic [CpW-1:0] SurrFirst = 21'h00D800;
    localparam logic [CpW-1:0] SurrLast  = 21'h00DFFF;

    typedef enum logic [2:0] {
        MODE_LEAD  = 3'b001,
        MODE_CONT  = 3'b010,
        MODE_TRASH = 3'b100
    } t_mode;

    typedef struct packed {
        logic           rune_valid;
        logic [CpW-1:0] code_point;
        logic           seq_error;
        logic           end_rune;
    } t_result;

endpackage

FILE: rtl/u8d_stream_if.sv
// ----------------------------------------------------------------------------
// u8d_in_if / u8d_out_if
// Valid/ready channels for raw bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface u8d_in_if;
    logic                        valid;
    logic                        ready;
    logic [u8d_pkg::ByteW-1:0]   data_byte;
    logic                        end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface u8d_out_if;
    logic                        valid;
    logic                        ready;
    logic                        rune_valid;
    logic [u8d_pkg::CpW-1:0]     code_point;
    logic                        seq_error;
    logic                        end_rune;

    modport source (output valid, output rune_valid, output code_point,
                    output seq_error, output end_rune, input ready);
    modport sink   (input valid, input rune_valid, input code_point,
                    input seq_error, input end_rune, output ready);
endinterface

FILE: rtl/utf8_validating_decoder.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// Decodes a UTF-8 byte stream into code points with full validation.
// ----------------------------------------------------------------------------
// Input channel i_in: one raw byte per transaction, or an end marker
// (end_of_input = 1, data_byte ignored). Output channel o_out: exactly one
// result per input transaction: a code point (rune_valid), an error
// (seq_error), an end marker (end_rune, with seq_error if a sequence was
// cut short), or an all-zero result while a sequence is in progress or
// bytes are dropped after an error.
// A byte lands in the input register at acceptance; the result register
// loads from the decode step when the input register advances. Throughput:
// one transaction per cycle while o_out is not stalled; the decode step
// between the two registers carries the per-byte state.
// When o_out stalls, the result register holds and the input register
// fills; i_in.ready drops only when both are full and the output is
// stalled. Synchronous active-low reset returns to lead-byte mode and
// empties both registers.
// ----------------------------------------------------------------------------
module utf8_validating_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8d_in_if.sink       i_in,
    u8d_out_if.source    o_out
);

    logic                          r_in_valid;
    logic [u8d_pkg::ByteW-1:0]     r_in_byte;
    logic                          r_in_eoi;
    logic                          r_out_valid;
    u8d_pkg::t_result              r_out;
    u8d_pkg::t_result              step_res;
    logic                          advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    u8d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.rune_valid = r_out.rune_valid;
    assign o_out.code_point = r_out.code_point;
    assign o_out.seq_error  = r_out.seq_error;
    assign o_out.end_rune   = r_out.end_rune;

endmodule

FILE: rtl/u8d_core.sv
// ----------------------------------------------------------------------------
// u8d_core
// Decoder state and per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module u8d_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [u8d_pkg::ByteW-1:0]     i_byte,
    input  logic                          i_eoi,
    output u8d_pkg::t_result              o_res
);

    u8d_pkg::t_mode                   r_mode,  n_mode;
    logic [u8d_pkg::CpW-1:0]          r_accum, n_accum;
    logic [u8d_pkg::LeftW-1:0]        r_left,  n_left;
    logic [u8d_pkg::MinW-1:0]         r_min,   n_min;
    u8d_pkg::t_result                 res;
    logic [u8d_pkg::CpW-1:0]          cont_acc;
    logic                             is_lead;
    logic                             bad_value;

    assign cont_acc = {r_accum[u8d_pkg::CpW-7:0], i_byte[5:0]};
    assign is_lead  = i_byte inside {[8'h00:8'h7F], [8'hC0:8'hF7]};
    assign bad_value = (cont_acc < {4'b0, r_min}) || (cont_acc >= u8d_pkg::CpLimit) ||
                       (cont_acc >= u8d_pkg::SurrFirst && cont_acc <= u8d_pkg::SurrLast);

    always_comb begin
        logic take_lead;
        take_lead = 1'b0;
        n_mode    = r_mode;
        n_accum   = r_accum;
        n_left    = r_left;
        n_min     = r_min;
        res       = '0;

        case (r_mode)
            u8d_pkg::MODE_CONT: begin
                if (i_eoi) begin
                    n_mode        = u8d_pkg::MODE_LEAD;
                    res.seq_error = 1'b1;
                    res.end_rune  = 1'b1;
                end else if (i_byte[7:6] != 2'b10) begin
                    n_mode        = u8d_pkg::MODE_TRASH;
                    res.seq_error = 1'b1;
                end else begin
                    n_accum = cont_acc;
                    if (r_left > 2'd1) begin
                        n_left = r_left - 2'd1;
                    end else begin
                        n_left = '0;
                        if (bad_value) begin
                            n_mode        = u8d_pkg::MODE_TRASH;
                            res.seq_error = 1'b1;
                        end else begin
                            n_mode         = u8d_pkg::MODE_LEAD;
                            res.rune_valid = 1'b1;
                            res.code_point = cont_acc;
                        end
                    end
                end
            end
            u8d_pkg::MODE_TRASH: begin
                take_lead = i_eoi || is_lead;
            end
            default: begin
                take_lead = 1'b1;
            end
        endcase

        if (take_lead) begin
            n_mode = u8d_pkg::MODE_LEAD;
            if (i_eoi) begin
                res.end_rune = 1'b1;
            end else begin
                case (i_byte) inside
                    [8'h00:8'h7F]: begin
                        res.rune_valid = 1'b1;
                        res.code_point = {13'b0, i_byte};
                    end
                    [8'hC0:8'hDF]: begin
                        n_accum = {13'b0, i_byte & u8d_pkg::Mask2Lead};
                        n_left  = 2'd1;
                        n_min   = u8d_pkg::Min2;
                        n_mode  = u8d_pkg::MODE_CONT;
                    end
                    [8'hE0:8'hEF]: begin
                        n_accum = {13'b0, i_byte & u8d_pkg::Mask3Lead};
                        n_left  = 2'd2;
                        n_min   = u8d_pkg::Min3;
                        n_mode  = u8d_pkg::MODE_CONT;
                    end
                    [8'hF0:8'hF7]: begin
                        n_accum = {13'b0, i_byte & u8d_pkg::Mask4Lead};
                        n_left  = 2'd3;
                        n_min   = u8d_pkg::Min4;
                        n_mode  = u8d_pkg::MODE_CONT;
                    end
                    default: begin
                        n_mode        = u8d_pkg::MODE_TRASH;
                        res.seq_error = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= u8d_pkg::MODE_LEAD;
            r_accum <= '0;
            r_left  <= '0;
            r_min   <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_min   <= n_min;
        end
    end

    assign o_res = res;

    a_cont_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == u8d_pkg::MODE_CONT |-> r_left != '0)
        else $error("continuation mode with no bytes left");

    a_eoi_to_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_eoi |=> r_mode == u8d_pkg::MODE_LEAD)
        else $error("end of input did not return to lead mode");

    a_error_to_trash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.seq_error && !i_eoi |=> r_mode == u8d_pkg::MODE_TRASH)
        else $error("error without trash mode");

    a_rune_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.rune_valid |-> res.code_point < u8d_pkg::CpLimit && !res.seq_error)
        else $error("illegal code point emitted");

endmodule

FILE: bench/utf8_validating_decoder_checker.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder_checker
// Watches both channels of the decoder, predicts one result per accepted
// input transaction and compares every accepted output transaction with the
// oldest pending prediction. Reports fails, pending, runes, errors, ends.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    u8d_in_if      i_in_mon,
    u8d_out_if     i_out_mon,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_rune_count,
    output int     o_error_count,
    output int     o_end_count
);
    timeunit 1ns;
    timeprecision 1ps;

    u8d_pkg::t_mode                   dec_mode;
    logic [u8d_pkg::CpW-1:0]          cp_acc;
    logic [u8d_pkg::LeftW-1:0]        cont_left;
    logic [u8d_pkg::MinW-1:0]         min_cp;

    u8d_pkg::t_result                 expected_q [$];

    function automatic u8d_pkg::t_result lead_step(input logic [u8d_pkg::ByteW-1:0] b,
                                                   input logic eoi);
        u8d_pkg::t_result r;
        r = '0;
        dec_mode = u8d_pkg::MODE_LEAD;
        if (eoi) begin
            r.end_rune = 1'b1;
        end else if (!b[7]) begin
            r.rune_valid = 1'b1;
            r.code_point = {13'b0, b};
        end else if (b[7:5] == 3'b110) begin
            cp_acc    = {13'b0, b & u8d_pkg::Mask2Lead};
            cont_left = 2'd1;
            min_cp    = u8d_pkg::Min2;
            dec_mode  = u8d_pkg::MODE_CONT;
        end else if (b[7:4] == 4'b1110) begin
            cp_acc    = {13'b0, b & u8d_pkg::Mask3Lead};
            cont_left = 2'd2;
            min_cp    = u8d_pkg::Min3;
            dec_mode  = u8d_pkg::MODE_CONT;
        end else if (b[7:3] == 5'b11110) begin
            cp_acc    = {13'b0, b & u8d_pkg::Mask4Lead};
            cont_left = 2'd3;
            min_cp    = u8d_pkg::Min4;
            dec_mode  = u8d_pkg::MODE_CONT;
        end else begin
            dec_mode    = u8d_pkg::MODE_TRASH;
            r.seq_error = 1'b1;
        end
        return r;
    endfunction

    function automatic u8d_pkg::t_result decode_step(input logic [u8d_pkg::ByteW-1:0] b,
                                                     input logic eoi);
        u8d_pkg::t_result r;
        logic             starts_seq;
        r = '0;
        starts_seq = !b[7] || (b[7:5] == 3'b110) || (b[7:4] == 4'b1110) ||
                     (b[7:3] == 5'b11110);
        case (dec_mode)
            u8d_pkg::MODE_CONT: begin
                if (eoi) begin
                    dec_mode    = u8d_pkg::MODE_LEAD;
                    r.seq_error = 1'b1;
                    r.end_rune  = 1'b1;
                end else if (b[7:6] != 2'b10) begin
                    // offending byte is swallowed, even a lead
                    dec_mode    = u8d_pkg::MODE_TRASH;
                    r.seq_error = 1'b1;
                end else begin
                    cp_acc = {cp_acc[u8d_pkg::CpW-7:0], b[5:0]};
                    if (cont_left > 2'd1) begin
                        cont_left = cont_left - 2'd1;
                    end else begin
                        cont_left = '0;
                        if (cp_acc < {4'b0, min_cp} || cp_acc >= u8d_pkg::CpLimit ||
                            (cp_acc >= u8d_pkg::SurrFirst &&
                             cp_acc <= u8d_pkg::SurrLast)) begin
                            dec_mode    = u8d_pkg::MODE_TRASH;
                            r.seq_error = 1'b1;
                        end else begin
                            dec_mode     = u8d_pkg::MODE_LEAD;
                            r.rune_valid = 1'b1;
                            r.code_point = cp_acc;
                        end
                    end
                end
            end
            u8d_pkg::MODE_TRASH: begin
                if (eoi || starts_seq) r = lead_step(b, eoi);
            end
            default: begin
                r = lead_step(b, eoi);
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        u8d_pkg::t_result want;
        u8d_pkg::t_result got;
        if (!i_rst_n) begin
            dec_mode  = u8d_pkg::MODE_LEAD;
            cp_acc    = '0;
            cont_left = '0;
            min_cp    = '0;
            expected_q.delete();
            o_fail_count  <= 0;
            o_pending     <= 0;
            o_rune_count  <= 0;
            o_error_count <= 0;
            o_end_count   <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_q.insert(expected_q.size(),
                                  decode_step(i_in_mon.data_byte, i_in_mon.end_of_input));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.rune_valid, i_out_mon.code_point,
                       i_out_mon.seq_error, i_out_mon.end_rune};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected result rv=%b cp=%h err=%b end=%b",
                                 $realtime, got.rune_valid, got.code_point,
                                 got.seq_error, got.end_rune);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  exp rv=%b cp=%h err=%b end=%b",
                                     want.rune_valid, want.code_point,
                                     want.seq_error, want.end_rune);
                            $display("  got rv=%b cp=%h err=%b end=%b",
                                     got.rune_valid, got.code_point,
                                     got.seq_error, got.end_rune);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                    o_rune_count  <= o_rune_count + int'(want.rune_valid);
                    o_error_count <= o_error_count + int'(want.seq_error);
                    o_end_count   <= o_end_count + int'(want.end_rune);
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

FILE: bench/utf8_validating_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder_tb
// Drives byte and end-marker transactions into the decoder: a directed set
// of boundary and error sequences, then randomized streams in which under half
// of the chunks are well-formed UTF-8, mixed with overlong, out-of-range, surrogate,
// truncated and noise sequences, under three sender/receiver stall mixes. The
// checker beside the decoder predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PhaseItems    = 650;
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned DrainCycles   = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_in_if  in_if ();
    u8d_out_if out_if ();

    int          fail_count;
    int          pending;
    int          rune_count;
    int          error_count;
    int          end_count;

    int unsigned src_idle_pct = 7;
    int unsigned snk_idle_pct = 45;
    int unsigned n_items;
    int unsigned quiet_cycles = 0;

    utf8_validating_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    utf8_validating_decoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_if),
        .i_out_mon     (out_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_rune_count  (rune_count),
        .o_error_count (error_count),
        .o_end_count   (end_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic [u8d_pkg::ByteW-1:0] b, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        n_items++;
    endtask

    // Encodes cp in nbytes bytes (overlong or out-of-range allowed) and sends
    // the first keep of them.
    task automatic send_encoded(input logic [u8d_pkg::CpW-1:0] cp,
                                input int unsigned nbytes,
                                input int unsigned keep);
        logic [u8d_pkg::ByteW-1:0] seq [4];
        case (nbytes)
            1: begin
                seq[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int unsigned k = 0; k < keep; k++) send_item(seq[k], 1'b0);
    endtask

    task automatic send_random_chunk();
        int unsigned                kind;
        int unsigned                len;
        int unsigned                cnt;
        logic [u8d_pkg::CpW-1:0]    lo;
        logic [u8d_pkg::CpW-1:0]    hi;
        logic [u8d_pkg::CpW-1:0]    cp;
        kind = $urandom_range(99);
        len  = (kind < 45) ? $urandom_range(1, 4) : $urandom_range(2, 4);
        case (len)
            1:       begin lo = 21'h000000; hi = 21'h00007F; end
            2:       begin lo = 21'h000080; hi = 21'h0007FF; end
            3:       begin lo = 21'h000800; hi = 21'h00FFFF; end
            default: begin lo = 21'h010000; hi = 21'h10FFFF; end
        endcase
        if (kind < 45) begin
            cp = 21'($urandom_range(lo, hi));
            if ($urandom_range(7) == 0) cp = $urandom_range(1) ? hi : lo;
            if (cp >= u8d_pkg::SurrFirst && cp <= u8d_pkg::SurrLast) cp = cp ^ 21'h008000;
            send_encoded(cp, len, len);
        end else if (kind < 55) begin
            send_encoded(21'($urandom_range(0, lo - 1)), len, len);
        end else if (kind < 60) begin
            send_encoded(21'($urandom_range(u8d_pkg::CpLimit, 21'h1FFFFF)), 4, 4);
        end else if (kind < 65) begin
            send_encoded(21'($urandom_range(u8d_pkg::SurrFirst, u8d_pkg::SurrLast)), 3, 3);
        end else if (kind < 75) begin
            send_encoded(21'($urandom_range(lo, hi)), len, $urandom_range(1, len - 1));
            send_item(8'($urandom), 1'($urandom_range(1)));
        end else if (kind < 87) begin
            cnt = $urandom_range(1, 3);
            repeat (cnt) send_item(8'($urandom), 1'b0);
        end else if (kind < 92) begin
            send_item(8'($urandom), 1'b1);
        end else begin
            send_item(8'($urandom_range(8'hC0, 8'hF7)), 1'b0);
            cnt = $urandom_range(1, 3);
            repeat (cnt) send_item(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        int unsigned phase_end;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= '0;
        in_if.end_of_input <= 1'b0;
        n_items      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ASCII and two-byte bounds
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        send_encoded(21'h000080, 2, 2);
        send_encoded(21'h0007FF, 2, 2);
        // bad lead, dropped continuation, ASCII ends the trash
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h41, 1'b0);
        // bad continuation swallows the ASCII byte, end while dropping
        send_item(8'hC3, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h00, 1'b1);
        // end in mid-sequence
        send_item(8'hE2, 1'b0);
        send_item(8'h82, 1'b0);
        send_item(8'hA5, 1'b1);
        // overlong, surrogate, lead resyncs trash, four-byte bound, end in lead
        send_encoded(21'h000000, 2, 2);
        send_encoded(21'h00D800, 3, 3);
        send_encoded(21'h010000, 4, 4);
        send_item(8'hFF, 1'b1);

        phase_end = n_items + PhaseItems;
        while (n_items < phase_end) send_random_chunk();
        src_idle_pct = 45;
        snk_idle_pct = 7;
        phase_end = n_items + PhaseItems;
        while (n_items < phase_end) send_random_chunk();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        phase_end = n_items + PhaseItems;
        while (n_items < phase_end) send_random_chunk();
        in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d byte/end transactions under three stall mixes", n_items);
        $display("Checked %0d code points, %0d sequence errors, %0d end markers",
                 rune_count, error_count, end_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/u8d_pkg.sv
rtl/u8d_stream_if.sv
rtl/u8d_core.sv
rtl/utf8_validating_decoder.sv
bench/utf8_validating_decoder_checker.sv
bench/utf8_validating_decoder_tb.sv
